@@ rtl/core/bcc_pkg.sv @@
// shared types and constants for the button click classifier
`default_nettype none

package bcc_pkg;

    localparam int unsigned CfgIndexWidth = 8;
    localparam int unsigned CfgDataWidth  = 8;

    // register indexes on the configuration port
    localparam logic [CfgIndexWidth-1:0] REG_LONG_PRESS_TICKS = 8'd0;
    localparam logic [CfgIndexWidth-1:0] REG_WINDOW_STEPS     = 8'd1;
    localparam logic [CfgIndexWidth-1:0] REG_DEBOUNCE_TICKS   = 8'd2;
    localparam logic [CfgIndexWidth-1:0] REG_SLOT_TICKS       = 8'd3;

    // register values after reset
    localparam logic [7:0] LONG_PRESS_TICKS_RST = 8'd200;
    localparam logic [7:0] WINDOW_STEPS_RST     = 8'd10;
    localparam logic [3:0] DEBOUNCE_TICKS_RST   = 4'd2;
    localparam logic [3:0] SLOT_TICKS_RST       = 4'd2;

    localparam logic [7:0] TICK_MAX = 8'd255;

    typedef enum logic [2:0] {
        PH_IDLE         = 3'd0,
        PH_DEBOUNCE     = 3'd1,
        PH_HOLD         = 3'd2,
        PH_LONG_WAIT    = 3'd3,
        PH_SLOT_WAIT    = 3'd4,
        PH_SLOT_DEBOUNCE = 3'd5,
        PH_SLOT_RELEASE = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } gesture_t;

endpackage

`default_nettype wire

@@ rtl/core/button_click_classifier_top.sv @@
// button click classifier: debounce, click window and long-press detection
//
// usage
// - one request on the s_ channel per 10 ms key sample (s_key_down, 1 = pressed)
// - each request yields exactly one result on the m_ channel: the LED levels
//   after that tick (m_led_one, m_led_two) and the gesture decided on that tick
//   (m_gesture: none, single click, double click, long press)
// - the result is registered: a request accepted at edge n is shown on m_ from
//   edge n, i.e. m_valid is high in the following cycle
// - throughput is one request per cycle while the receiver is ready; the whole
//   tick update is a single pass through the phase/counter logic into the result register
// - a stalled receiver holds the result register; s_ready follows
//   !m_valid || m_ready, so a new request is taken in the same cycle the
//   pending result leaves
// - configuration writes (cfg_ channel) are always accepted and take effect
//   for the next request; indexes beyond the register list are ignored
// - synchronous reset (aresetn low) returns to idle, clears counters and both
//   LEDs, empties the result register and restores the register defaults
`default_nettype none

module button_click_classifier_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // key samples
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_key_down,
    // results
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_led_one,
    output logic                                     m_led_two,
    output logic [1:0]                               m_gesture,
    // register writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bcc_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  wire logic [bcc_pkg::CfgDataWidth-1:0]    cfg_data
);

    import bcc_pkg::*;

    // configuration registers
    logic [7:0] long_press_ticks_reg;
    logic [7:0] window_steps_reg;
    logic [3:0] debounce_ticks_reg;
    logic [3:0] slot_ticks_reg;

    // classifier state
    phase_t     phase_reg, phase_next;
    logic [7:0] tick_count_reg, tick_count_next;
    logic [7:0] slot_count_reg, slot_count_next;
    logic       double_seen_reg, double_seen_next;
    logic       led_one_reg, led_one_next;
    logic       led_two_reg, led_two_next;

    // result register
    logic       m_valid_reg;
    gesture_t   gesture_reg, gesture_next;

    logic       s_accept;
    logic       cfg_accept;

    // shared decode of the current tick
    logic [7:0] tick_inc;
    logic       debounce_done;
    logic       hold_limit;
    logic       slot_done;
    logic       window_end;

    assign s_ready    = !m_valid_reg || m_ready;
    assign s_accept   = s_valid && s_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    assign m_valid   = m_valid_reg;
    assign m_led_one = led_one_reg;
    assign m_led_two = led_two_reg;
    assign m_gesture = gesture_reg;

    // saturating held-tick count; a zero limit behaves like one
    assign tick_inc      = (tick_count_reg == TICK_MAX) ? tick_count_reg
                                                        : tick_count_reg + 8'd1;
    assign debounce_done = tick_inc >= {4'd0, debounce_ticks_reg};
    assign hold_limit    = tick_inc >= long_press_ticks_reg;
    assign slot_done     = tick_inc >= {4'd0, slot_ticks_reg};
    // the slot being closed is the last of the window
    assign window_end    = slot_count_reg >= window_steps_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_press_ticks_reg <= LONG_PRESS_TICKS_RST;
            window_steps_reg     <= WINDOW_STEPS_RST;
            debounce_ticks_reg   <= DEBOUNCE_TICKS_RST;
            slot_ticks_reg       <= SLOT_TICKS_RST;
        end else if (cfg_accept) begin
            case (cfg_index)
                REG_LONG_PRESS_TICKS: long_press_ticks_reg <= cfg_data;
                REG_WINDOW_STEPS:     window_steps_reg     <= cfg_data;
                REG_DEBOUNCE_TICKS:   debounce_ticks_reg   <= cfg_data[3:0];
                REG_SLOT_TICKS:       slot_ticks_reg       <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // next phase and counters
    always_comb begin
        phase_next       = phase_reg;
        tick_count_next  = tick_count_reg;
        slot_count_next  = slot_count_reg;
        double_seen_next = double_seen_reg;
        case (phase_reg)
            PH_DEBOUNCE: begin
                tick_count_next = tick_inc;
                if (debounce_done) begin
                    tick_count_next = 8'd0;
                    phase_next      = s_key_down ? PH_HOLD : PH_IDLE;
                end
            end
            PH_HOLD: begin
                tick_count_next = tick_inc;
                if (hold_limit) begin
                    if (s_key_down) begin
                        phase_next = PH_LONG_WAIT;
                    end else begin
                        phase_next      = PH_IDLE;
                        tick_count_next = 8'd0;
                    end
                end else if (!s_key_down) begin
                    // short press opens the click window
                    phase_next       = PH_SLOT_WAIT;
                    tick_count_next  = 8'd0;
                    slot_count_next  = 8'd0;
                    double_seen_next = 1'b0;
                end
            end
            PH_LONG_WAIT: begin
                if (!s_key_down) begin
                    phase_next      = PH_IDLE;
                    tick_count_next = 8'd0;
                end
            end
            PH_SLOT_WAIT, PH_SLOT_DEBOUNCE, PH_SLOT_RELEASE: begin
                if (phase_reg != PH_SLOT_RELEASE) begin
                    tick_count_next = tick_inc;
                end
                if (phase_reg == PH_SLOT_WAIT && slot_done && s_key_down) begin
                    tick_count_next = 8'd0;
                    phase_next      = PH_SLOT_DEBOUNCE;
                end else if (phase_reg == PH_SLOT_DEBOUNCE && debounce_done
                             && s_key_down) begin
                    double_seen_next = 1'b1;
                    tick_count_next  = 8'd0;
                    phase_next       = PH_SLOT_RELEASE;
                end else if ((phase_reg == PH_SLOT_WAIT && slot_done)
                             || (phase_reg == PH_SLOT_DEBOUNCE && debounce_done)
                             || (phase_reg == PH_SLOT_RELEASE && !s_key_down)) begin
                    // slot closes
                    tick_count_next = 8'd0;
                    if (window_end) begin
                        phase_next       = PH_IDLE;
                        slot_count_next  = 8'd0;
                        double_seen_next = 1'b0;
                    end else begin
                        phase_next      = PH_SLOT_WAIT;
                        slot_count_next = slot_count_reg + 8'd1;
                    end
                end
            end
            default: begin
                // idle and the unused code
                tick_count_next = 8'd0;
                phase_next      = s_key_down ? PH_DEBOUNCE : PH_IDLE;
            end
        endcase
    end

    // gesture and LED levels
    always_comb begin
        gesture_next = EV_NONE;
        case (phase_reg)
            PH_HOLD: begin
                if (hold_limit && !s_key_down) begin
                    gesture_next = EV_LONG;
                end
            end
            PH_LONG_WAIT: begin
                if (!s_key_down) begin
                    gesture_next = EV_LONG;
                end
            end
            PH_SLOT_WAIT: begin
                if (slot_done && !s_key_down && window_end && !double_seen_reg) begin
                    gesture_next = EV_SINGLE;
                end
            end
            PH_SLOT_DEBOUNCE: begin
                if (debounce_done) begin
                    if (s_key_down) begin
                        gesture_next = EV_DOUBLE;
                    end else if (window_end && !double_seen_reg) begin
                        gesture_next = EV_SINGLE;
                    end
                end
            end
            PH_SLOT_RELEASE: begin
                if (!s_key_down && window_end && !double_seen_reg) begin
                    gesture_next = EV_SINGLE;
                end
            end
            default: gesture_next = EV_NONE;
        endcase

        led_one_next = led_one_reg;
        led_two_next = led_two_reg;
        case (gesture_next)
            EV_LONG: begin
                led_one_next = 1'b1;
                led_two_next = 1'b1;
            end
            EV_DOUBLE: begin
                led_one_next = 1'b0;
                led_two_next = 1'b0;
            end
            EV_SINGLE: led_one_next = !led_one_reg;
            default: ;
        endcase
    end

    // state and result update, one request per cycle while s_ready is high
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            tick_count_reg  <= 8'd0;
            slot_count_reg  <= 8'd0;
            double_seen_reg <= 1'b0;
            led_one_reg     <= 1'b0;
            led_two_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (s_accept) begin
                phase_reg       <= phase_next;
                tick_count_reg  <= tick_count_next;
                slot_count_reg  <= slot_count_next;
                double_seen_reg <= double_seen_next;
                led_one_reg     <= led_one_next;
                led_two_reg     <= led_two_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // the gesture code is payload only
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            gesture_reg <= gesture_next;
        end
    end

    // a long press result always shows both LEDs lit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && gesture_reg == EV_LONG |-> led_one_reg && led_two_reg)
        else $error("long press without both LEDs lit");

    // a double click result always shows both LEDs dark
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && gesture_reg == EV_DOUBLE |-> !led_one_reg && !led_two_reg)
        else $error("double click without both LEDs cleared");

    // waiting for release after a double click implies the flag is set
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_SLOT_RELEASE |-> double_seen_reg)
        else $error("slot release without double click seen");

    // the double click flag lives only inside the click window
    assert property (@(posedge aclk) disable iff (!aresetn)
        double_seen_reg |-> phase_reg == PH_SLOT_WAIT
                            || phase_reg == PH_SLOT_DEBOUNCE
                            || phase_reg == PH_SLOT_RELEASE)
        else $error("double click flag set outside the window");

    // release after a long hold returns to idle with a long press result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && phase_reg == PH_LONG_WAIT && !s_key_down
        |=> phase_reg == PH_IDLE && gesture_reg == EV_LONG)
        else $error("long press release not reported");

endmodule

`default_nettype wire
